// ----- rtl/fcc_pkg.sv -----
// fcc_pkg: shared types, constants and the crc byte update for the frame checker
// no dependencies

package fcc_pkg;

    localparam int FRAME_LENGTH_DEF = 16;
    localparam int ADDR_W           = 3;
    localparam int DATA_W           = 32;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  HEADER_RESET = 8'hA5;

    // register index, taken from paddr[2]
    localparam logic REG_HEADER = 1'b0;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SHORT  = 2'd1,
        ST_HEADER = 2'd2,
        ST_CRC    = 2'd3
    } fcc_status_t;

    typedef struct packed {
        fcc_status_t status;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
    } fcc_result_t;

    // crc-16/modbus, reflected, one byte lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/fcc_cfg_regs.sv -----
// fcc_cfg_regs: apb-style register port holding the expected header byte
// depends on fcc_pkg

module fcc_cfg_regs
    import fcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [7:0]        header_value
);

    logic [7:0] header_reg;
    logic [7:0] header_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_HEADER);

    always_comb
    begin
        header_next = header_reg;
        if (wr_en)
        begin
            header_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
        end
        else
        begin
            header_reg <= header_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_HEADER: prdata = {{(DATA_W-8){1'b0}}, header_reg};
            default:    prdata = '0;
        endcase
    end

    assign header_value = header_reg;

endmodule

// ----- rtl/fcc_frame_track.sv -----
// fcc_frame_track: per-frame byte count, running crc, header flag and checksum capture
// depends on fcc_pkg

module fcc_frame_track
    import fcc_pkg::*;
#(
    parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        end_of_frame,
    input  logic [7:0]  header_value,
    output fcc_result_t result
);

    localparam int CW = $clog2(FRAME_LENGTH + 1);
    localparam logic [CW-1:0] FL_C    = CW'(FRAME_LENGTH);
    localparam logic [CW-1:0] FL_M2_C = CW'(FRAME_LENGTH - 2);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [15:0]   crc_reg;
    logic [15:0]   crc_next;
    logic          hdr_ok_reg;
    logic          hdr_ok_next;
    logic [15:0]   chk_reg;
    logic [15:0]   chk_next;

    logic [CW-1:0] cnt_upd;
    logic [15:0]   crc_upd;
    logic          hdr_upd;
    logic [15:0]   chk_upd;

    always_comb
    begin
        cnt_upd = count_reg;
        crc_upd = crc_reg;
        hdr_upd = hdr_ok_reg;
        chk_upd = chk_reg;
        if (count_reg < FL_C)
        begin
            if (count_reg == '0)
            begin
                hdr_upd = (data_byte == header_value);
            end
            if (count_reg < FL_M2_C)
            begin
                crc_upd = crc16_byte(crc_reg, data_byte);
            end
            else if (count_reg == FL_M2_C)
            begin
                chk_upd = {chk_reg[15:8], data_byte};
            end
            else
            begin
                chk_upd = {data_byte, chk_reg[7:0]};
            end
            cnt_upd = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        if (cnt_upd < FL_C)
        begin
            result.status       = ST_SHORT;
            result.computed_crc = '0;
            result.received_crc = '0;
        end
        else
        begin
            if (!hdr_upd)
            begin
                result.status = ST_HEADER;
            end
            else if (crc_upd != chk_upd)
            begin
                result.status = ST_CRC;
            end
            else
            begin
                result.status = ST_OK;
            end
            result.computed_crc = crc_upd;
            result.received_crc = chk_upd;
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        crc_next    = crc_reg;
        hdr_ok_next = hdr_ok_reg;
        chk_next    = chk_reg;
        if (accept)
        begin
            if (end_of_frame)
            begin
                count_next  = '0;
                crc_next    = CRC_INIT;
                hdr_ok_next = 1'b0;
                chk_next    = '0;
            end
            else
            begin
                count_next  = cnt_upd;
                crc_next    = crc_upd;
                hdr_ok_next = hdr_upd;
                chk_next    = chk_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            crc_reg    <= CRC_INIT;
            hdr_ok_reg <= 1'b0;
            chk_reg    <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            hdr_ok_reg <= hdr_ok_next;
            chk_reg    <= chk_next;
        end
    end

endmodule

// ----- rtl/fcc_out_stage.sv -----
// fcc_out_stage: result register with valid/ready handshake toward the receiver
// depends on fcc_pkg

module fcc_out_stage
    import fcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  fcc_result_t load_data,
    output logic        can_load,
    output logic        out_valid,
    input  logic        out_ready,
    output fcc_result_t out_data
);

    logic        valid_reg;
    logic        valid_next;
    fcc_result_t data_reg;
    fcc_result_t data_next;

    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = load_data;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/framed_packet_crc_checker_unit.sv -----
// framed_packet_crc_checker_unit: top level of the crc-16/modbus frame checker
// depends on fcc_pkg, fcc_cfg_regs, fcc_frame_track, fcc_out_stage
//
// usage
//   input channel (in_valid/in_ready) carries one frame byte per request,
//   end_of_frame set on the last byte; one byte is taken every cycle while in_ready is high
//   output channel (out_valid/out_ready) gives one result per frame:
//   status, crc over the first FRAME_LENGTH-2 bytes, and the checksum from
//   the last two bytes, low byte first
//   the flagged last byte's result is registered into the output register as
//   that byte is accepted; other bytes give no result
//   throughput is one byte per cycle while in_ready is high; the byte-wide
//   crc update is combinational between the frame state registers
//   when the receiver stalls, the result holds and in_ready stays high only
//   while out_ready is high, so a byte is taken in the same cycle a waiting
//   result leaves
//   reset clears the frame state, empties the output register and sets
//   header_value to 0xa5; the apb port holds header_value at address 0

module framed_packet_crc_checker_unit
    import fcc_pkg::*;
#(
    parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              end_of_frame,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [15:0]       computed_crc,
    output logic [15:0]       received_crc
);

    logic        [7:0] header_value;
    logic              accept;
    logic              can_load;
    fcc_result_t       frame_res;
    fcc_result_t       out_data;

    assign in_ready = can_load;
    assign accept   = in_valid && can_load;

    fcc_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .header_value (header_value)
    );

    fcc_frame_track #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .end_of_frame (end_of_frame),
        .header_value (header_value),
        .result       (frame_res)
    );

    fcc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && end_of_frame),
        .load_data (frame_res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign status       = out_data.status;
    assign computed_crc = out_data.computed_crc;
    assign received_crc = out_data.received_crc;

endmodule

// ----- rtl/fcc_checker.sv -----
// fcc_checker: port-level assertions for the frame checker, bound to the top level
// depends on fcc_pkg and framed_packet_crc_checker_unit

module fcc_checker
    import fcc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        end_of_frame,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [15:0] computed_crc,
    input logic [15:0] received_crc
);

    // a flagged byte always produces a result next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_frame |=> out_valid)
        else $error("no result after last byte");

    // input side opens exactly when the output register can take a result
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not track output register");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_SHORT) |-> (computed_crc == 16'h0) && (received_crc == 16'h0))
        else $error("short frame with nonzero crc fields");

    a_ok_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) |-> computed_crc == received_crc)
        else $error("ok status with crc mismatch");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(computed_crc))
        else $error("stalled result changed");

endmodule

bind framed_packet_crc_checker_unit fcc_checker u_fcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .end_of_frame (end_of_frame),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .computed_crc (computed_crc),
    .received_crc (received_crc)
);
